// ===== design/awsc_pkg.sv =====
// Package for the window step counter: sizes, register codes, sequencer
// states and the command and status types shared by controller and datapath.
// Depends on nothing.
package awsc_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SMP_W        = 24;
  localparam int SQ_W         = 2 * SMP_W;
  localparam int REM_W        = SMP_W + 2;
  localparam int HSUM_W       = 16 + ADDR_W;
  localparam int TSUM_W       = 16 + ADDR_W;
  localparam int MSUM_W       = SMP_W + ADDR_W;
  localparam int HN_W         = 32 + CNT_W;
  localparam int BND_W        = HN_W + 1;
  localparam int CN_W         = SMP_W + CNT_W;
  localparam int STEP_W       = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam int DIV_STEPS    = HSUM_W;
  localparam int SQRT_STEPS   = SMP_W;
  localparam int ITER_W       = $clog2(HSUM_W);
  localparam int IDX_W        = 3;
  localparam int CFG_W        = 23;

  localparam logic [15:0] ALPHA_RST     = 16'd7209;
  localparam logic [15:0] HEIGHT_RST    = 16'd8;
  localparam logic [9:0]  GAP_RST       = 10'd6;
  localparam logic [7:0]  STREAK_RST    = 8'd3;
  localparam logic [9:0]  SILENCE_RST   = 10'd50;
  localparam logic [22:0] RAW_LVL_RST   = 23'd128000;
  localparam logic [15:0] RAW_SCALE_RST = 16'd2000;
  localparam logic [23:0] LEVEL_RST     = 24'd256;
  localparam logic [9:0]  SINCE_RST     = 10'd1000;
  localparam logic [9:0]  SINCE_MAX     = 10'd1023;
  localparam logic [7:0]  STREAK_MAX    = 8'd255;

  typedef enum logic [IDX_W-1:0] {
    REG_FILTER_ALPHA     = 3'd0,
    REG_MIN_PEAK_HEIGHT  = 3'd1,
    REG_MIN_STEP_GAP     = 3'd2,
    REG_STREAK_TO_START  = 3'd3,
    REG_SILENCE_TIMEOUT  = 3'd4,
    REG_RAW_DETECT_LEVEL = 3'd5,
    REG_RAW_HEIGHT_SCALE = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_FILT_A, OP_FILT_B, OP_STORE, OP_H, OP_HN, OP_BOUND, OP_RD, OP_SHIFT,
    OP_CN, OP_EVAL, OP_SILENCE, OP_HR_INIT, OP_DIV_STEP, OP_HR_DONE,
    OP_TP_INIT, OP_TP_DONE, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SQ_X, S_SQ_Y, S_SQ_Z, S_SQRT_INIT, S_SQRT, S_FILT_A,
    S_FILT_B, S_STORE, S_H, S_HN, S_BOUND, S_RD, S_SHIFT, S_CN, S_EVAL, S_SIL,
    S_HR_INIT, S_HR_DIV, S_HR_DONE, S_TP_INIT, S_TP_DIV, S_TP_DONE, S_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic lt_depth;
    logic ge3;
    logic last;
    logic k_ge2;
    logic scan_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/awsc_ctrl.sv =====
// Sequencer of the window step counter: per-sample and end-of-window steps.
// Depends on awsc_pkg.
module awsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  awsc_pkg::stat_t stat,
  output awsc_pkg::cmd_t  cmd
);
  import awsc_pkg::*;

  state_t              state, state_next;
  logic [ITER_W-1:0]   iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = '0;
    cmd.op     = OP_NONE;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.lt_depth) state_next = S_SQ_X;
        else if (stat.last) state_next = S_H;
        else state_next = S_IDLE;
      end
      S_SQ_X: begin cmd.op = OP_SQ_X; state_next = S_SQ_Y; end
      S_SQ_Y: begin cmd.op = OP_SQ_Y; state_next = S_SQ_Z; end
      S_SQ_Z: begin cmd.op = OP_SQ_Z; state_next = S_SQRT_INIT; end
      S_SQRT_INIT: begin cmd.op = OP_SQRT_INIT; state_next = S_SQRT; end
      S_SQRT: begin
        cmd.op    = OP_SQRT_STEP;
        iter_next = iter + 1'b1;
        if (iter == ITER_W'(SQRT_STEPS - 1)) state_next = S_FILT_A;
      end
      S_FILT_A: begin cmd.op = OP_FILT_A; state_next = S_FILT_B; end
      S_FILT_B: begin cmd.op = OP_FILT_B; state_next = S_STORE; end
      S_STORE: begin
        cmd.op     = OP_STORE;
        state_next = stat.last ? S_H : S_IDLE;
      end
      S_H: begin cmd.op = OP_H; state_next = S_HN; end
      S_HN: begin cmd.op = OP_HN; state_next = S_BOUND; end
      S_BOUND: begin
        cmd.op     = OP_BOUND;
        state_next = stat.ge3 ? S_RD : S_SIL;
      end
      S_RD: begin cmd.op = OP_RD; state_next = S_SHIFT; end
      S_SHIFT: begin
        cmd.op     = OP_SHIFT;
        state_next = stat.k_ge2 ? S_CN : S_RD;
      end
      S_CN: begin cmd.op = OP_CN; state_next = S_EVAL; end
      S_EVAL: begin
        cmd.op     = OP_EVAL;
        state_next = stat.scan_done ? S_SIL : S_RD;
      end
      S_SIL: begin cmd.op = OP_SILENCE; state_next = S_HR_INIT; end
      S_HR_INIT: begin cmd.op = OP_HR_INIT; state_next = S_HR_DIV; end
      S_HR_DIV: begin
        cmd.op    = OP_DIV_STEP;
        iter_next = iter + 1'b1;
        if (iter == ITER_W'(DIV_STEPS - 1)) state_next = S_HR_DONE;
      end
      S_HR_DONE: begin cmd.op = OP_HR_DONE; state_next = S_TP_INIT; end
      S_TP_INIT: begin cmd.op = OP_TP_INIT; state_next = S_TP_DIV; end
      S_TP_DIV: begin
        cmd.op    = OP_DIV_STEP;
        iter_next = iter + 1'b1;
        if (iter == ITER_W'(DIV_STEPS - 1)) state_next = S_TP_DONE;
      end
      S_TP_DONE: begin cmd.op = OP_TP_DONE; state_next = S_EMIT; end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/awsc_dp.sv =====
// Datapath of the window step counter: config registers, magnitude, filter,
// window store, peak test, shared divider and output register. Uses awsc_pkg.
module awsc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  awsc_pkg::cmd_t                  cmd,
  output awsc_pkg::stat_t                 stat,
  input  logic signed [23:0]              accel_x,
  input  logic signed [23:0]              accel_y,
  input  logic signed [23:0]              accel_z,
  input  logic [15:0]                     heart_rate_tenths,
  input  logic signed [15:0]              temp_hundredths,
  input  logic [31:0]                     sample_time,
  input  logic                            last_in_window,
  input  logic                            cfg_we,
  input  logic [awsc_pkg::IDX_W-1:0]      cfg_index,
  input  logic [awsc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [15:0]                     avg_heart_rate_x10,
  output logic signed [15:0]              mean_temp_centi,
  output logic [7:0]                      steps,
  output logic [31:0]                     window_time
);
  import awsc_pkg::*;

  logic [15:0] filter_alpha, min_peak_height, raw_height_scale;
  logic [9:0]  min_step_gap, silence_timeout;
  logic [7:0]  streak_to_start;
  logic [22:0] raw_detect_level;

  logic [SMP_W-1:0]         filter_level;
  logic [9:0]               since_step;
  logic [7:0]               streak_count;
  logic                     walking, raw_mode, last;
  logic [CNT_W-1:0]         stored_count, k;
  logic [HSUM_W-1:0]        heart_sum;
  logic signed [TSUM_W-1:0] temp_total;
  logic [MSUM_W-1:0]        magnitude_sum;
  logic [31:0]              last_time;

  logic [SMP_W-1:0]  ax, ay, az, root, prv, cur, nxt, rdata;
  logic [15:0]       hr_in;
  logic signed [15:0] tp_in;
  logic [31:0]       time_in;
  logic [SQ_W-1:0]   sq;
  logic [REM_W-1:0]  srem;
  logic [REM_W:0]    srem_sh, strial;
  logic [40:0]       prod_a;
  logic [39:0]       prod_b;
  logic [41:0]       facc;
  logic [31:0]       h;
  logic [HN_W-1:0]   hn;
  logic [BND_W-1:0]  bound;
  logic [CN_W-1:0]   cn;
  logic [STEP_W-1:0] step_cnt;
  logic [HSUM_W-1:0] quo;
  logic [CNT_W-1:0]  drem;
  logic [CNT_W:0]    drem_sh;
  logic              tneg;
  logic [15:0]       hr_res, tp_res;
  logic [CNT_W-1:0]  nsel;
  logic [9:0]        since_inc;
  logic [7:0]        streak_inc;
  logic              is_peak;
  logic [SMP_W-1:0]  store_mem [WINDOW_DEPTH];

  assign nsel       = (stored_count == '0) ? CNT_W'(1) : stored_count;
  assign since_inc  = (since_step == SINCE_MAX) ? since_step : since_step + 10'd1;
  assign streak_inc = (streak_count == STREAK_MAX) ? streak_count : streak_count + 8'd1;
  assign is_peak    = (cur > prv) && (cur > nxt) && (BND_W'(cn) > bound) &&
                      (since_inc > min_step_gap);
  assign srem_sh    = {srem[REM_W-2:0], sq[SQ_W-1 -: 2]};
  assign strial     = {1'b0, root, 2'b01};
  assign drem_sh    = {drem, quo[HSUM_W-1]};
  assign facc       = 42'(prod_a) + 42'(prod_b) + 42'd32768;

  assign stat.lt_depth  = stored_count < CNT_W'(WINDOW_DEPTH);
  assign stat.ge3       = stored_count >= CNT_W'(3);
  assign stat.last      = last;
  assign stat.k_ge2     = k >= CNT_W'(2);
  assign stat.scan_done = (k == stored_count);
  assign stat.out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha     <= ALPHA_RST;
      min_peak_height  <= HEIGHT_RST;
      min_step_gap     <= GAP_RST;
      streak_to_start  <= STREAK_RST;
      silence_timeout  <= SILENCE_RST;
      raw_detect_level <= RAW_LVL_RST;
      raw_height_scale <= RAW_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_ALPHA:     filter_alpha     <= cfg_data[15:0];
        REG_MIN_PEAK_HEIGHT:  min_peak_height  <= cfg_data[15:0];
        REG_MIN_STEP_GAP:     min_step_gap     <= cfg_data[9:0];
        REG_STREAK_TO_START:  streak_to_start  <= cfg_data[7:0];
        REG_SILENCE_TIMEOUT:  silence_timeout  <= cfg_data[9:0];
        REG_RAW_DETECT_LEVEL: raw_detect_level <= cfg_data;
        REG_RAW_HEIGHT_SCALE: raw_height_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE) store_mem[stored_count[ADDR_W-1:0]] <= facc[39:16];
    if (cmd.op == OP_RD) rdata <= store_mem[k[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_level  <= LEVEL_RST;
      since_step    <= SINCE_RST;
      streak_count  <= '0;
      walking       <= 1'b0;
      stored_count  <= '0;
      raw_mode      <= 1'b0;
      heart_sum     <= '0;
      temp_total    <= '0;
      magnitude_sum <= '0;
      last_time     <= '0;
      last          <= 1'b0;
      k             <= '0;
      step_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_LATCH: begin
          ax      <= accel_x[23] ? SMP_W'(-accel_x) : SMP_W'(accel_x);
          ay      <= accel_y[23] ? SMP_W'(-accel_y) : SMP_W'(accel_y);
          az      <= accel_z[23] ? SMP_W'(-accel_z) : SMP_W'(accel_z);
          hr_in   <= heart_rate_tenths;
          tp_in   <= temp_hundredths;
          time_in <= sample_time;
          last    <= last_in_window;
          if (stored_count == '0)
            raw_mode <= (accel_x[23] ? SMP_W'(-accel_x) : SMP_W'(accel_x)) >
                        {1'b0, raw_detect_level};
        end
        OP_SQ_X: sq <= ax * ax;
        OP_SQ_Y: sq <= sq + ay * ay;
        OP_SQ_Z: sq <= sq + az * az;
        OP_SQRT_INIT: begin
          srem <= '0;
          root <= '0;
        end
        OP_SQRT_STEP: begin
          sq <= {sq[SQ_W-3:0], 2'b00};
          if (srem_sh >= strial) begin
            srem <= REM_W'(srem_sh - strial);
            root <= {root[SMP_W-2:0], 1'b1};
          end else begin
            srem <= REM_W'(srem_sh);
            root <= {root[SMP_W-2:0], 1'b0};
          end
        end
        OP_FILT_A: prod_a <= filter_level * (17'h10000 - {1'b0, filter_alpha});
        OP_FILT_B: prod_b <= root * filter_alpha;
        OP_STORE: begin
          filter_level  <= facc[39:16];
          magnitude_sum <= magnitude_sum + MSUM_W'(facc[39:16]);
          heart_sum     <= heart_sum + HSUM_W'(hr_in);
          temp_total    <= temp_total + TSUM_W'(tp_in);
          last_time     <= time_in;
          stored_count  <= stored_count + 1'b1;
        end
        OP_H: h <= min_peak_height * (raw_mode ? raw_height_scale : 16'd1);
        OP_HN: hn <= h * nsel;
        OP_BOUND: begin
          bound    <= BND_W'(magnitude_sum) + BND_W'(hn);
          k        <= '0;
          step_cnt <= '0;
        end
        OP_RD: ;
        OP_SHIFT: begin
          prv <= cur;
          cur <= nxt;
          nxt <= rdata;
          k   <= k + 1'b1;
        end
        OP_CN: cn <= cur * nsel;
        OP_EVAL: begin
          if (is_peak) begin
            since_step   <= '0;
            streak_count <= streak_inc;
            if (walking) begin
              step_cnt <= step_cnt + 1'b1;
            end else if (streak_inc >= streak_to_start) begin
              walking  <= 1'b1;
              step_cnt <= step_cnt + STEP_W'(streak_to_start);
            end
          end else begin
            since_step <= since_inc;
          end
        end
        OP_SILENCE: begin
          if (step_cnt == '0 && since_step > silence_timeout) begin
            streak_count <= '0;
            walking      <= 1'b0;
          end
        end
        OP_HR_INIT: begin
          quo  <= heart_sum;
          drem <= '0;
        end
        OP_DIV_STEP: begin
          if (drem_sh >= {1'b0, nsel}) begin
            drem <= CNT_W'(drem_sh - {1'b0, nsel});
            quo  <= {quo[HSUM_W-2:0], 1'b1};
          end else begin
            drem <= CNT_W'(drem_sh);
            quo  <= {quo[HSUM_W-2:0], 1'b0};
          end
        end
        OP_HR_DONE: hr_res <= (quo > HSUM_W'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
        OP_TP_INIT: begin
          tneg <= temp_total[TSUM_W-1];
          quo  <= temp_total[TSUM_W-1] ? HSUM_W'(-temp_total) : HSUM_W'(temp_total);
          drem <= '0;
        end
        OP_TP_DONE: begin
          if (tneg) tp_res <= (quo >= HSUM_W'(32768)) ? 16'h8000 : 16'(-quo[15:0]);
          else tp_res <= (quo > HSUM_W'(32767)) ? 16'h7FFF : quo[15:0];
        end
        OP_EMIT: begin
          avg_heart_rate_x10 <= hr_res;
          mean_temp_centi    <= tp_res;
          steps              <= (step_cnt > STEP_W'(255)) ? 8'd255 : step_cnt[7:0];
          window_time        <= last_time;
          stored_count       <= '0;
          heart_sum          <= '0;
          temp_total         <= '0;
          magnitude_sum      <= '0;
          raw_mode           <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/accel_window_step_counter_top.sv =====
// Top level of the window step counter: joins sequencer and datapath.
// Depends on awsc_pkg, awsc_ctrl and awsc_dp.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | accel_x/y/z, heart_rate_tenths,
//          |                     | temp_hundredths, sample_time, last_in_window
//  out     | out_valid/out_stall | avg_heart_rate_x10, mean_temp_centi, steps,
//          |                     | window_time
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Between one accepted sample and the next, with the input stalled, a stored
// sample runs the depth check, three squares, root setup, a 24-step
// bit-serial square root, two filter products and the store write. A window
// end runs bound setup, a scan of the stored samples when there are at least
// three (one store read port), the silence check, two bit-serial divisions
// and the emit. The emit waits only while a previous result stalls.
// The output register lets the next sample in while a result waits.
// Reset is synchronous; no clearing pass is needed. cfg_ready stays high.
module accel_window_step_counter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [23:0]         accel_x,
  input  logic signed [23:0]         accel_y,
  input  logic signed [23:0]         accel_z,
  input  logic [15:0]                heart_rate_tenths,
  input  logic signed [15:0]         temp_hundredths,
  input  logic [31:0]                sample_time,
  input  logic                       last_in_window,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                avg_heart_rate_x10,
  output logic signed [15:0]         mean_temp_centi,
  output logic [7:0]                 steps,
  output logic [31:0]                window_time,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [awsc_pkg::IDX_W-1:0] cfg_index,
  input  logic [awsc_pkg::CFG_W-1:0] cfg_data
);
  import awsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  awsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  awsc_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .accel_x            (accel_x),
    .accel_y            (accel_y),
    .accel_z            (accel_z),
    .heart_rate_tenths  (heart_rate_tenths),
    .temp_hundredths    (temp_hundredths),
    .sample_time        (sample_time),
    .last_in_window     (last_in_window),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .avg_heart_rate_x10 (avg_heart_rate_x10),
    .mean_temp_centi    (mean_temp_centi),
    .steps              (steps),
    .window_time        (window_time)
  );

endmodule

// ===== design/awsc_checker.sv =====
// Port-level checks of the window step counter, bound to the top level.
// Depends on accel_window_step_counter_top.
module awsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  steps,
  input logic [31:0] window_time
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while input side was open");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(steps) && $stable(window_time))
    else $error("stalled result changed");

endmodule

bind accel_window_step_counter_top awsc_checker u_awsc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .steps       (steps),
  .window_time (window_time)
);
